@@ hw/rtl/trle_pkg.sv @@
// Package for the text run-length encoder: payload structs, run command type
// and the constants shared by the front end, the command queue and the back end.
// No dependencies.
package trle_pkg;

    localparam int MAX_RUN   = 9999;
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    // run limit in four BCD digits, worked out at elaboration
    localparam logic [15:0] MAX_RUN_BCD = {
        4'((MAX_RUN / 1000) % 10),
        4'((MAX_RUN / 100) % 10),
        4'((MAX_RUN / 10) % 10),
        4'(MAX_RUN % 10)
    };
    localparam logic [15:0] BCD_ONE   = 16'h0001;
    localparam logic [15:0] BCD_TWO   = 16'h0002;
    localparam logic [15:0] BCD_THREE = 16'h0003;
    localparam logic [7:0]  ASCII_ZERO = 8'h30;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_burst;
        logic       stream_done;
    } t_out;

    typedef struct packed {
        logic [7:0]  run_char;
        logic [15:0] run_bcd;
    } t_run;

    // one command per input beat that causes output: a closed run and,
    // at the end of the string, the final run
    typedef struct packed {
        logic a_valid;
        t_run a;
        logic last;
        t_run b;
    } t_cmd;

endpackage

@@ hw/rtl/trle_front.sv @@
// Front end of the run-length encoder: tracks the open run and issues run commands.
// Depends on trle_pkg.
module trle_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  trle_pkg::t_in i_data,
    input  logic          i_full,
    output logic          o_cmd_push,
    output trle_pkg::t_cmd o_cmd
);

    logic [7:0]  r_held;
    logic [15:0] r_bcd;
    logic        r_open;
    logic [7:0]  n_held;
    logic [15:0] n_bcd;
    logic        n_open;
    logic        w_accept;
    logic        w_cont;

    function automatic logic [15:0] bcd_inc(input logic [15:0] b);
        logic [15:0] r;
        logic        carry;
        logic [3:0]  d;
        r     = '0;
        carry = 1'b1;
        for (int k = 0; k < 4; k++) begin
            d = b[4*k +: 4];
            if (carry && d == 4'd9) begin
                d = 4'd0;
            end else begin
                d     = d + 4'(carry);
                carry = 1'b0;
            end
            r[4*k +: 4] = d;
        end
        return r;
    endfunction

    assign w_accept = i_push && !i_full;
    assign w_cont   = r_open && (i_data.in_byte == r_held) && (r_bcd < trle_pkg::MAX_RUN_BCD);

    always_comb begin
        n_held = r_held;
        n_bcd  = r_bcd;
        n_open = r_open;
        o_cmd.a_valid    = 1'b0;
        o_cmd.a.run_char = r_held;
        o_cmd.a.run_bcd  = r_bcd;
        o_cmd.last       = i_data.end_of_string;
        if (w_cont) begin
            n_bcd = bcd_inc(r_bcd);
        end else begin
            // close the open run and start a new one
            o_cmd.a_valid = r_open;
            n_held = i_data.in_byte;
            n_bcd  = trle_pkg::BCD_ONE;
            n_open = 1'b1;
        end
        o_cmd.b.run_char = n_held;
        o_cmd.b.run_bcd  = n_bcd;
        if (i_data.end_of_string) begin
            n_held = '0;
            n_bcd  = '0;
            n_open = 1'b0;
        end
    end

    assign o_cmd_push = w_accept && (o_cmd.a_valid || o_cmd.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_bcd  <= '0;
            r_open <= 1'b0;
        end else if (w_accept) begin
            r_held <= n_held;
            r_bcd  <= n_bcd;
            r_open <= n_open;
        end
    end

endmodule

@@ hw/rtl/trle_cmd_fifo.sv @@
// Short command queue between the front end and the back end of the encoder.
// Depends on trle_pkg.
module trle_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  trle_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output trle_pkg::t_cmd o_data,
    output logic           o_empty
);

    trle_pkg::t_cmd                r_mem [trle_pkg::CMD_DEPTH];
    logic [trle_pkg::CMD_AW-1:0]   r_wr;
    logic [trle_pkg::CMD_AW-1:0]   r_rd;
    logic [trle_pkg::CMD_AW:0]     r_cnt;
    logic                          w_wr;
    logic                          w_rd;

    assign o_full  = (r_cnt == (trle_pkg::CMD_AW+1)'(trle_pkg::CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/trle_back.sv @@
// Back end of the encoder: expands run commands into output bytes, one per cycle
// while popped, through a registered output stage. Depends on trle_pkg.
module trle_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  trle_pkg::t_cmd i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output trle_pkg::t_out o_data
);

    localparam logic [2:0] STEP_D3   = 3'd0;
    localparam logic [2:0] STEP_D2   = 3'd1;
    localparam logic [2:0] STEP_D1   = 3'd2;
    localparam logic [2:0] STEP_D0   = 3'd3;
    localparam logic [2:0] STEP_CHAR = 3'd4;

    logic           r_busy;
    trle_pkg::t_run r_run;
    logic [2:0]     r_step;
    logic           r_final;
    trle_pkg::t_run r_b;
    logic           r_done;
    logic           r_out_valid;
    trle_pkg::t_out r_out;

    logic           w_adv;
    logic           w_run_end;
    logic           w_cmd_end;
    logic           w_big;
    logic [3:0]     w_digit;
    logic [7:0]     w_byte;

    // first step of a run: leading digit for long runs, char repeats otherwise
    function automatic logic [2:0] start_step(input logic [15:0] b);
        logic [2:0] s;
        if (b >= trle_pkg::BCD_THREE) begin
            if (b[15:12] != 4'd0) begin
                s = STEP_D3;
            end else if (b[11:8] != 4'd0) begin
                s = STEP_D2;
            end else if (b[7:4] != 4'd0) begin
                s = STEP_D1;
            end else begin
                s = STEP_D0;
            end
        end else if (b == trle_pkg::BCD_TWO) begin
            s = STEP_D0;
        end else begin
            s = STEP_CHAR;
        end
        return s;
    endfunction

    assign w_adv     = !r_out_valid || i_pop;
    assign w_run_end = (r_step == STEP_CHAR);
    assign w_cmd_end = w_run_end && r_final;
    assign w_big     = (r_run.run_bcd >= trle_pkg::BCD_THREE);
    assign o_cmd_pop = !i_cmd_empty && (!r_busy || (w_adv && w_cmd_end));

    always_comb begin
        case (r_step)
            STEP_D3: w_digit = r_run.run_bcd[15:12];
            STEP_D2: w_digit = r_run.run_bcd[11:8];
            STEP_D1: w_digit = r_run.run_bcd[7:4];
            STEP_D0: w_digit = r_run.run_bcd[3:0];
            default: w_digit = 4'd0;
        endcase
        if (w_run_end || !w_big) begin
            w_byte = r_run.run_char;
        end else begin
            w_byte = trle_pkg::ASCII_ZERO + {4'd0, w_digit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_busy;
            end
            if (o_cmd_pop) begin
                r_busy <= 1'b1;
            end else if (w_adv && w_cmd_end) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_busy) begin
            r_out.out_byte      <= w_byte;
            r_out.last_of_burst <= w_cmd_end;
            r_out.stream_done   <= w_cmd_end && r_done;
            if (!w_run_end) begin
                r_step <= r_step + 1'b1;
            end else if (!r_final) begin
                // move on to the final run of this command
                r_run   <= r_b;
                r_step  <= start_step(r_b.run_bcd);
                r_final <= 1'b1;
            end
        end
        if (o_cmd_pop) begin
            r_b    <= i_cmd.b;
            r_done <= i_cmd.last;
            if (i_cmd.a_valid) begin
                r_run   <= i_cmd.a;
                r_step  <= start_step(i_cmd.a.run_bcd);
                r_final <= !i_cmd.last;
            end else begin
                r_run   <= i_cmd.b;
                r_step  <= start_step(i_cmd.b.run_bcd);
                r_final <= 1'b1;
            end
        end
    end

    assign o_empty = !r_out_valid;
    assign o_data  = r_out;

endmodule

@@ hw/rtl/text_run_length_encoder.sv @@
// Text run-length encoder, top level. Depends on trle_pkg, trle_front,
// trle_cmd_fifo and trle_back.
// A burst's first byte goes through the command queue and the back end's output register.
// Throughput: one input beat per cycle while the four-entry command queue has room;
// output is one byte per cycle while popped, set by the single expander and output register.
// Reset: synchronous, active low; clears the open run, the command queue and the output stage.
module text_run_length_encoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  trle_pkg::t_in  i_data,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output trle_pkg::t_out o_data
);

    logic           w_cmd_push;
    trle_pkg::t_cmd w_cmd_in;
    logic           w_cmd_full;
    logic           w_cmd_pop;
    trle_pkg::t_cmd w_cmd_out;
    logic           w_cmd_empty;

    trle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (i_data),
        .i_full     (w_cmd_full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in)
    );

    trle_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    trle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_data      (o_data)
    );

    assign full = w_cmd_full;

    a_no_cmd_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> !w_cmd_full)
        else $error("command pushed into a full queue");

    a_cmd_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> (w_cmd_in.a_valid || w_cmd_in.last))
        else $error("command queued that produces no bytes");

    a_done_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data.stream_done) |-> o_data.last_of_burst)
        else $error("stream end flagged inside a burst");

endmodule
